// ----- rtl/bdq_pkg.sv -----
// Shared types and constants of the bounded deque with reverse.
package bdq_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int MODE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD = 2'd0,
        MODE_INS_TAIL = 2'd1,
        MODE_REM_HEAD = 2'd2,
        MODE_REVERSE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic ins_head;
        logic ins_tail;
        logic rem_head;
        logic reverse;
        logic load_res;
        logic load_rd;
        logic ok;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_status;

endpackage

// ----- rtl/bdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bdq_ctrl.sv -----
// Operation sequencer: decodes each transfer and steps the datapath.
module bdq_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [bdq_pkg::MODE_W-1:0]         i_mode,
    input  bdq_pkg::t_status                   i_status,
    output bdq_pkg::t_cmd                      o_cmd,
    output logic                               busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state        r_state;
    t_state        n_state;
    bdq_pkg::t_cmd cmd;
    logic          accept;

    assign accept = start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (bdq_pkg::t_mode'(i_mode))
                        bdq_pkg::MODE_INS_HEAD: begin
                            cmd.ins_head = !i_status.full;
                            cmd.ok       = !i_status.full;
                            cmd.load_res = 1'b1;
                        end
                        bdq_pkg::MODE_INS_TAIL: begin
                            cmd.ins_tail = !i_status.full;
                            cmd.ok       = !i_status.full;
                            cmd.load_res = 1'b1;
                        end
                        bdq_pkg::MODE_REM_HEAD: begin
                            if (i_status.empty) begin
                                cmd.load_res = 1'b1;
                            end else begin
                                cmd.rem_head = 1'b1;
                                n_state      = ST_READ;
                            end
                        end
                        bdq_pkg::MODE_REVERSE: begin
                            cmd.reverse  = 1'b1;
                            cmd.ok       = 1'b1;
                            cmd.load_res = 1'b1;
                        end
                        default: begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.load_rd = 1'b1;
                cmd.ok      = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;
    assign busy  = (r_state == ST_READ);

endmodule

// ----- rtl/bdq_dpath.sv -----
// Ring pointers, count, direction flag, element store and result registers.
module bdq_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bdq_pkg::t_cmd                         i_cmd,
    input  logic signed [bdq_pkg::DATA_W-1:0]     i_value_in,
    output bdq_pkg::t_status                      o_status,
    output logic                                  o_done,
    output logic                                  o_ok,
    output logic signed [bdq_pkg::DATA_W-1:0]     o_removed_value,
    output logic [bdq_pkg::COUNT_W-1:0]           o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_X   = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (CAP_X - {1'b0, b});
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    logic [AW-1:0]                       r_head;
    logic [AW-1:0]                       n_head;
    logic [CW-1:0]                       r_occ;
    logic [CW-1:0]                       n_occ;
    logic                                r_rev;
    logic                                n_rev;
    logic                                r_valid;
    logic                                r_ok;
    logic signed [bdq_pkg::DATA_W-1:0]   r_removed;
    logic [CW-1:0]                       r_count;

    logic [AW-1:0]                       occ_lo;
    logic [AW-1:0]                       occ_m1;
    logic [AW-1:0]                       before_head;
    logic [AW-1:0]                       after_tail;
    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    logic [bdq_pkg::DATA_W-1:0]          rd_data;

    assign occ_lo      = r_occ[AW-1:0];
    assign occ_m1      = AW'(r_occ - CW'(1));
    assign before_head = r_rev ? ring_add(r_head, AW'(1)) : ring_sub(r_head, AW'(1));
    assign after_tail  = r_rev ? ring_sub(r_head, occ_lo) : ring_add(r_head, occ_lo);

    always_comb begin
        n_head  = r_head;
        n_occ   = r_occ;
        n_rev   = r_rev;
        wr_en   = 1'b0;
        wr_addr = after_tail;
        if (i_cmd.ins_head) begin
            wr_en   = 1'b1;
            wr_addr = before_head;
            n_head  = before_head;
            n_occ   = r_occ + CW'(1);
        end
        if (i_cmd.ins_tail) begin
            wr_en = 1'b1;
            n_occ = r_occ + CW'(1);
        end
        if (i_cmd.rem_head) begin
            n_head = r_rev ? ring_sub(r_head, AW'(1)) : ring_add(r_head, AW'(1));
            n_occ  = r_occ - CW'(1);
        end
        if (i_cmd.reverse) begin
            if (r_occ != '0) begin
                n_head = r_rev ? ring_sub(r_head, occ_m1) : ring_add(r_head, occ_m1);
            end
            n_rev = ~r_rev;
        end
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_value_in),
        .i_re    (i_cmd.rem_head),
        .i_raddr (r_head),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_occ   <= '0;
            r_rev   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_occ   <= n_occ;
            r_rev   <= n_rev;
            r_valid <= i_cmd.load_res || i_cmd.load_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_ok      <= i_cmd.ok;
            r_removed <= '0;
            r_count   <= n_occ;
        end else if (i_cmd.load_rd) begin
            r_ok      <= i_cmd.ok;
            r_removed <= rd_data;
            r_count   <= n_occ;
        end
    end

    assign o_status.full   = (r_occ == CAP_CNT);
    assign o_status.empty  = (r_occ == '0);
    assign o_done          = r_valid;
    assign o_ok            = r_ok;
    assign o_removed_value = r_removed;
    assign o_count         = bdq_pkg::COUNT_W'(r_count);

endmodule

// ----- rtl/bounded_deque_with_reverse.sv -----
// Bounded double-ended queue of signed 32-bit values over a ring store, with reverse.
// Insert at head, insert at tail and reverse: result strobe in the cycle after the transfer,
//   busy stays low, one operation per cycle.
// Remove from head: if empty, it fails with its result strobe in the next cycle; else busy
//   is high in ST_READ for the registered store read, and no transfer is taken then.
// Reset clears head slot, count and direction; store contents are left as they are.
module bounded_deque_with_reverse #(
    parameter int CAPACITY = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic [bdq_pkg::MODE_W-1:0]            i_mode,
    input  logic signed [bdq_pkg::DATA_W-1:0]     i_value_in,
    output logic                                  busy,
    output logic                                  o_done,
    output logic                                  o_ok,
    output logic signed [bdq_pkg::DATA_W-1:0]     o_removed_value,
    output logic [bdq_pkg::COUNT_W-1:0]           o_count
);

    bdq_pkg::t_cmd    cmd;
    bdq_pkg::t_status status;
    logic             xfer;

    assign xfer = start && !busy;

    bdq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    bdq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value_in      (i_value_in),
        .o_status        (status),
        .o_done          (o_done),
        .o_ok            (o_ok),
        .o_removed_value (o_removed_value),
        .o_count         (o_count)
    );

    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && (i_mode != bdq_pkg::MODE_REM_HEAD) |=> o_done)
        else $error("result missing after single-cycle operation");

    a_reverse_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && (i_mode == bdq_pkg::MODE_REVERSE) |=> o_done && o_ok)
        else $error("reverse did not report success");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_ok |-> o_removed_value == '0)
        else $error("failed operation returned a nonzero value");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_done && o_ok)
        else $error("store read did not complete in one cycle");

endmodule
